// ===== src/gradient_non_max_suppression_assert.svh =====
// assertion macros for the nms block
`ifndef GRADIENT_NON_MAX_SUPPRESSION_ASSERT_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_ASSERT_SVH

// implication checked on every clock edge outside reset
`define GNMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define GNMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/gnms_pkg.sv =====
`timescale 1ns / 1ps
package gnms_pkg;
  localparam int unsigned MagW   = 12;
  localparam int unsigned CoordW = 10;
  localparam int unsigned SizeW  = 11;
  localparam int unsigned MaxHeight = 1024;

  localparam logic [1:0] CfgWidth  = 2'd0;
  localparam logic [1:0] CfgHeight = 2'd1;
  localparam logic [1:0] CfgThresh = 2'd2;

  localparam logic [SizeW-1:0] WidthReset  = 11'd640;
  localparam logic [SizeW-1:0] HeightReset = 11'd480;

  typedef enum logic [1:0] {
    SecHoriz = 2'd0,
    SecDiagA = 2'd1,
    SecVert  = 2'd2,
    SecDiagB = 2'd3
  } sector_e;

  // item passed from front to back
  typedef struct packed {
    logic [MagW-1:0] mag;
    sector_e         sec;
  } pix_t;

  typedef enum logic {
    SqIdle = 1'b0,
    SqBusy = 1'b1
  } sqrt_state_e;
endpackage

// ===== src/gradient_non_max_suppression.sv =====
`timescale 1ns / 1ps
// channel   | valid       | stall       | payload
// in        | in_valid_i  | in_stall_o  | grad_x_i, grad_y_i
// out       | out_valid_o | out_stall_i | center_x_o, center_y_o, nms_magnitude_o
// cfg       | cfg_we_i    | -           | cfg_index_i, cfg_data_i
// the front takes no new item until its one-bit-a-cycle square root has finished the last one
// the back handles one item at a time, in two steps (line buffer read, then window update)
// reset clears counters, window and sector delay; line buffers hold garbage until written
// a two-entry queue lets the front keep working while the back waits on out_stall_i
`include "gradient_non_max_suppression_assert.svh"
module gradient_non_max_suppression #(
  parameter int unsigned MAX_WIDTH     = 1024,
  parameter int unsigned GRAD_BITS     = 12,
  parameter int unsigned ROT_FRAC_BITS = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [GRAD_BITS-1:0]       grad_x_i,
  input  logic signed [GRAD_BITS-1:0]       grad_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gnms_pkg::CoordW-1:0]       center_x_o,
  output logic [gnms_pkg::CoordW-1:0]       center_y_o,
  output logic [gnms_pkg::MagW-1:0]         nms_magnitude_o,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [gnms_pkg::MagW-1:0]         cfg_data_i
);
  logic [gnms_pkg::SizeW-1:0] width_q, height_q;
  logic [gnms_pkg::MagW-1:0]  thresh_q;
  logic f_valid, f_stall, b_valid, b_stall;
  gnms_pkg::pix_t f_pix, b_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gnms_pkg::WidthReset;
      height_q <= gnms_pkg::HeightReset;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gnms_pkg::CfgWidth:  width_q  <= cfg_data_i[gnms_pkg::SizeW-1:0];
        gnms_pkg::CfgHeight: height_q <= cfg_data_i[gnms_pkg::SizeW-1:0];
        gnms_pkg::CfgThresh: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gnms_front #(.GradBits(GRAD_BITS), .RotFracBits(ROT_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .grad_x_i, .grad_y_i,
    .pix_valid_o(f_valid), .pix_stall_i(f_stall), .pix_o(f_pix));

  gnms_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_pix),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_pix));

  gnms_back #(.MaxWidth(MAX_WIDTH)) u_back (
    .clk_i, .rst_ni, .pix_valid_i(b_valid), .pix_stall_o(b_stall), .pix_i(b_pix),
    .image_width_i(width_q), .image_height_i(height_q), .low_threshold_i(thresh_q),
    .out_valid_o, .out_stall_i, .center_x_o, .center_y_o, .nms_magnitude_o);

  `GNMS_ASSERT_IMPL(a_out_interior, out_valid_o, center_x_o != '0 && center_y_o != '0)
  `GNMS_ASSERT_IMPL(a_kept_thresh, out_valid_o && nms_magnitude_o != '0,
                    nms_magnitude_o >= thresh_q)
  `GNMS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
endmodule

// ===== src/gnms_ram.sv =====
`timescale 1ns / 1ps
module gnms_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== src/gnms_front.sv =====
`timescale 1ns / 1ps
// magnitude by bit-serial square root, sector by pi/8 rotation
module gnms_front #(
  parameter int unsigned GradBits    = 12,
  parameter int unsigned RotFracBits = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [GradBits-1:0] grad_x_i,
  input  logic signed [GradBits-1:0] grad_y_i,
  output logic                       pix_valid_o,
  input  logic                       pix_stall_i,
  output gnms_pkg::pix_t             pix_o
);
  localparam int unsigned SqW   = 2 * GradBits;
  localparam int unsigned RootW = GradBits;
  localparam int unsigned CntW  = $clog2(RootW + 1);
  localparam int unsigned ProdW = GradBits + RotFracBits + 3;
  localparam longint CosK = (((longint'(968758) * 2) >>> (20 - RotFracBits)) + 1) >>> 1;
  localparam longint SinK = (((longint'(401273) * 2) >>> (20 - RotFracBits)) + 1) >>> 1;
  localparam logic signed [ProdW-1:0] CosC = ProdW'(CosK);
  localparam logic signed [ProdW-1:0] SinC = ProdW'(SinK);

  gnms_pkg::sqrt_state_e state_q, state_d;
  logic [SqW-1:0]   rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic signed [ProdW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic out_valid_q, out_valid_d;
  gnms_pkg::pix_t out_q, out_d;

  logic accept;
  logic signed [ProdW-1:0] gx, gy, px, py;
  logic [SqW:0]    sq_sum;
  logic [RootW+1:0] trial;
  logic [SqW-1:0]  rem_sh;
  logic signed [ProdW-1:0] ax, ay;
  gnms_pkg::sector_e sec;

  assign in_stall_o  = (state_q != gnms_pkg::SqIdle) || (out_valid_q && pix_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign pix_valid_o = out_valid_q;
  assign pix_o       = out_q;

  always_comb begin
    gx = ProdW'(grad_x_i);
    gy = ProdW'(grad_y_i);
    sq_sum = (SqW+1)'($unsigned(gx * gx)) + (SqW+1)'($unsigned(gy * gy));
    // rotation by pi/8; scaled down on accept, truncating toward zero
    px = CosC * gx - SinC * gy;
    py = SinC * gx + CosC * gy;
  end

  always_comb begin
    ax = (ry_q < 0) ? -rx_q : rx_q;
    ay = (ry_q < 0) ? -ry_q : ry_q;
    if (ax > 0) begin
      sec = (ax >= ay) ? gnms_pkg::SecHoriz : gnms_pkg::SecDiagA;
    end else if (ax < 0) begin
      sec = (-ax < ay) ? gnms_pkg::SecVert : gnms_pkg::SecDiagB;
    end else begin
      sec = (ay == 0) ? gnms_pkg::SecHoriz : gnms_pkg::SecVert;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gnms_pkg::SqIdle: if (accept) state_d = gnms_pkg::SqBusy;
      gnms_pkg::SqBusy: if (cnt_q == CntW'(1)) state_d = gnms_pkg::SqIdle;
      default: state_d = gnms_pkg::SqIdle;
    endcase
  end

  always_comb begin
    rem_d = rem_q;
    root_d = root_q;
    cnt_d = cnt_q;
    rx_d = rx_q;
    ry_d = ry_q;
    out_d = out_q;
    out_valid_d = out_valid_q && pix_stall_i;
    trial = '0;
    rem_sh = '0;
    case (state_q)
      gnms_pkg::SqIdle: begin
        if (accept) begin
          rem_d  = sq_sum[SqW-1:0];
          root_d = '0;
          cnt_d  = CntW'(RootW);
          rx_d   = (px < 0) ? -((-px) >>> RotFracBits) : (px >>> RotFracBits);
          ry_d   = (py < 0) ? -((-py) >>> RotFracBits) : (py >>> RotFracBits);
        end
      end
      gnms_pkg::SqBusy: begin
        // one root bit per cycle, restoring form on the remainder top
        rem_sh = rem_q;
        trial  = {root_q, 2'b01};
        if ((RootW+2)'(rem_q >> (2 * (cnt_q - CntW'(1)))) >= trial) begin
          rem_d  = rem_sh - (SqW'(trial) << (2 * (cnt_q - CntW'(1))));
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          out_valid_d = 1'b1;
          out_d.mag = gnms_pkg::MagW'(root_d);
          out_d.sec = sec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gnms_pkg::SqIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    out_q  <= out_d;
  end
endmodule

// ===== src/gnms_fifo.sv =====
`timescale 1ns / 1ps
// two-entry queue between front and back
module gnms_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_stall_o,
  input  gnms_pkg::pix_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_stall_i,
  output gnms_pkg::pix_t rd_data_o
);
  gnms_pkg::pix_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule

// ===== src/gnms_back.sv =====
`timescale 1ns / 1ps
// line buffers, 3x3 window and suppression compare
module gnms_back #(
  parameter int unsigned MaxWidth = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pix_valid_i,
  output logic                           pix_stall_o,
  input  gnms_pkg::pix_t                 pix_i,
  input  logic [gnms_pkg::SizeW-1:0]     image_width_i,
  input  logic [gnms_pkg::SizeW-1:0]     image_height_i,
  input  logic [gnms_pkg::MagW-1:0]      low_threshold_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gnms_pkg::CoordW-1:0]    center_x_o,
  output logic [gnms_pkg::CoordW-1:0]    center_y_o,
  output logic [gnms_pkg::MagW-1:0]      nms_magnitude_o
);
  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned CW = $clog2(MaxWidth + 1) > gnms_pkg::SizeW ?
                               $clog2(MaxWidth + 1) : gnms_pkg::SizeW;
  localparam int unsigned MW = gnms_pkg::MagW;

  // phase 0: read line buffers; phase 1: shift window, write, emit
  logic busy_q;
  logic [CW-1:0] col_q, row_q, col_c, row_c, w_c, h_c;
  gnms_pkg::pix_t pix_q;
  logic [MW-1:0] win_q [3][3];
  gnms_pkg::sector_e sd_q [2];
  logic [MW-1:0] l0_rd, l1_rd;
  logic [1:0] s_rd;
  logic out_valid_q;
  logic [gnms_pkg::CoordW-1:0] cx_q, cy_q;
  logic [MW-1:0] om_q;
  logic take, fin;
  logic [MW-1:0] na, nb, ctr;
  logic keep;

  assign pix_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign take = pix_valid_i && !pix_stall_o;
  assign fin  = busy_q && !(out_valid_q && out_stall_i);

  always_comb begin
    w_c = CW'(image_width_i);
    h_c = CW'(image_height_i);
    if (w_c < CW'(3)) w_c = CW'(3);
    if (w_c > CW'(MaxWidth)) w_c = CW'(MaxWidth);
    if (h_c < CW'(3)) h_c = CW'(3);
    if (h_c > CW'(gnms_pkg::MaxHeight)) h_c = CW'(gnms_pkg::MaxHeight);
    col_c = col_q;
    row_c = row_q;
    // size changed under a running frame
    if (col_c >= w_c) begin
      col_c = '0;
      row_c = row_c + CW'(1);
    end
    if (row_c >= h_c) row_c = '0;
  end

  gnms_ram #(.Width(MW), .Depth(1 << AW)) u_line0 (
    .clk_i, .we_i(fin), .waddr_i(col_c[AW-1:0]), .wdata_i(pix_q.mag),
    .raddr_i(col_c[AW-1:0]), .rdata_o(l0_rd));
  gnms_ram #(.Width(MW), .Depth(1 << AW)) u_line1 (
    .clk_i, .we_i(fin), .waddr_i(col_c[AW-1:0]), .wdata_i(l0_rd),
    .raddr_i(col_c[AW-1:0]), .rdata_o(l1_rd));
  gnms_ram #(.Width(2), .Depth(1 << AW)) u_secline (
    .clk_i, .we_i(fin), .waddr_i(col_c[AW-1:0]), .wdata_i(pix_q.sec),
    .raddr_i(col_c[AW-1:0]), .rdata_o(s_rd));

  always_comb begin
    // window has not shifted yet: the new column is the line buffer reads
    ctr = win_q[1][2];
    case (sd_q[0])
      gnms_pkg::SecHoriz: begin na = win_q[1][1]; nb = l0_rd; end
      gnms_pkg::SecDiagA: begin na = win_q[0][1]; nb = pix_q.mag; end
      gnms_pkg::SecVert:  begin na = win_q[0][2]; nb = win_q[2][2]; end
      default:            begin na = win_q[2][1]; nb = l1_rd; end
    endcase
    keep = (ctr >= low_threshold_i) && (na <= ctr) && (nb <= ctr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      sd_q[0]     <= gnms_pkg::SecHoriz;
      sd_q[1]     <= gnms_pkg::SecHoriz;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (fin && col_c >= CW'(2) && row_c >= CW'(2)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        busy_q <= 1'b1;
      end else if (fin) begin
        busy_q <= 1'b0;
      end
      if (fin) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= l1_rd;
        win_q[1][2] <= l0_rd;
        win_q[2][2] <= pix_q.mag;
        sd_q[1] <= sd_q[0];
        sd_q[0] <= gnms_pkg::sector_e'(s_rd);
        if (col_c + CW'(1) >= w_c) begin
          col_q <= '0;
          row_q <= (row_c + CW'(1) >= h_c) ? '0 : row_c + CW'(1);
        end else begin
          col_q <= col_c + CW'(1);
          row_q <= row_c;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) pix_q <= pix_i;
    if (fin) begin
      cx_q <= gnms_pkg::CoordW'(col_c - CW'(1));
      cy_q <= gnms_pkg::CoordW'(row_c - CW'(1));
      om_q <= keep ? ctr : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign center_x_o      = cx_q;
  assign center_y_o      = cy_q;
  assign nms_magnitude_o = om_q;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned RotFrac   = 14;
  localparam longint      CosPi8    = (((64'sd968758 * 2) >>> (20 - RotFrac)) + 1) >>> 1;
  localparam longint      SinPi8    = (((64'sd401273 * 2) >>> (20 - RotFrac)) + 1) >>> 1;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 64;

  typedef struct {
    logic [gnms_pkg::CoordW-1:0] cx;
    logic [gnms_pkg::CoordW-1:0] cy;
    logic [gnms_pkg::MagW-1:0]   mag;
  } nms_result_t;

  typedef struct {
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    bit                 typed;
    nms_result_t        want;
  } grad_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [11:0] grad_x_i = '0;
  logic signed [11:0] grad_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [gnms_pkg::CoordW-1:0] center_x_o;
  logic [gnms_pkg::CoordW-1:0] center_y_o;
  logic [gnms_pkg::MagW-1:0] nms_magnitude_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = gnms_pkg::CfgWidth;
  logic [gnms_pkg::MagW-1:0] cfg_data_i = '0;

  gradient_non_max_suppression dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [gnms_pkg::SizeW-1:0] width_reg = gnms_pkg::WidthReset;
  logic [gnms_pkg::SizeW-1:0] height_reg = gnms_pkg::HeightReset;
  logic [gnms_pkg::MagW-1:0] thresh_reg = '0;
  logic [gnms_pkg::MagW-1:0] mag_line [2][MaxWidth];
  gnms_pkg::sector_e sec_line [MaxWidth];
  logic [gnms_pkg::MagW-1:0] win [3][3];
  gnms_pkg::sector_e sec_dly [2];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;

  nms_result_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_busy = 1'b0;
  bit no_gaps = 1'b0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;

  initial begin
    foreach (win[r, c]) win[r][c] = '0;
    sec_dly[0] = gnms_pkg::SecHoriz;
    sec_dly[1] = gnms_pkg::SecHoriz;
  end

  function automatic bit predict_pixel(input logic signed [11:0] gx,
                                       input logic signed [11:0] gy,
                                       output nms_result_t res);
    int unsigned w, h, col, row, a, b, ctr;
    longint x, y, v, root, bitv, rx, ry;
    logic [gnms_pkg::MagW-1:0] mag;
    gnms_pkg::sector_e sec;
    w = (width_reg < 3) ? 3 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
    h = (height_reg < 3) ? 3 :
        (height_reg > gnms_pkg::MaxHeight) ? gnms_pkg::MaxHeight : height_reg;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    x = gx;
    y = gy;
    // bitwise integer square root
    v = x * x + y * y;
    root = 0;
    bitv = 64'sd1 << 40;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    mag = root[gnms_pkg::MagW-1:0];
    // rotate by pi/8, truncating toward zero
    rx = (CosPi8 * x - SinPi8 * y) / (64'sd1 << RotFrac);
    ry = (SinPi8 * x + CosPi8 * y) / (64'sd1 << RotFrac);
    if (ry < 0) begin
      rx = -rx;
      ry = -ry;
    end
    if (rx > 0) sec = (rx >= ry) ? gnms_pkg::SecHoriz : gnms_pkg::SecDiagA;
    else if (rx < 0) sec = (-rx < ry) ? gnms_pkg::SecVert : gnms_pkg::SecDiagB;
    else sec = (ry == 0) ? gnms_pkg::SecHoriz : gnms_pkg::SecVert;

    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = mag_line[1][col];
    win[1][2] = mag_line[0][col];
    win[2][2] = mag;
    mag_line[1][col] = mag_line[0][col];
    mag_line[0][col] = mag;
    sec_dly[1] = sec_dly[0];
    sec_dly[0] = sec_line[col];
    sec_line[col] = sec;

    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
    if (col < 2 || row < 2) return 1'b0;

    ctr = win[1][1];
    case (sec_dly[1])
      gnms_pkg::SecHoriz: begin
        a = win[1][0];
        b = win[1][2];
      end
      gnms_pkg::SecDiagA: begin
        a = win[0][0];
        b = win[2][2];
      end
      gnms_pkg::SecVert: begin
        a = win[0][1];
        b = win[2][1];
      end
      default: begin
        a = win[2][0];
        b = win[0][2];
      end
    endcase
    res.cx = gnms_pkg::CoordW'(col - 1);
    res.cy = gnms_pkg::CoordW'(row - 1);
    res.mag = (ctr >= thresh_reg && a <= ctr && b <= ctr) ? gnms_pkg::MagW'(ctr) : '0;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [gnms_pkg::MagW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      gnms_pkg::CfgWidth:  width_reg = val[gnms_pkg::SizeW-1:0];
      gnms_pkg::CfgHeight: height_reg = val[gnms_pkg::SizeW-1:0];
      gnms_pkg::CfgThresh: thresh_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [gnms_pkg::MagW-1:0] w,
                           input logic [gnms_pkg::MagW-1:0] h,
                           input logic [gnms_pkg::MagW-1:0] thr);
    write_reg(gnms_pkg::CfgWidth, w);
    write_reg(gnms_pkg::CfgHeight, h);
    write_reg(gnms_pkg::CfgThresh, thr);
  endtask

  // one request, with burst gaps; typed expectations override the predictor
  task automatic send_grad(input grad_row_t item);
    int unsigned gap;
    nms_result_t res;
    bit has_res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(16, 1);
      gap = no_gaps ? 0 : $urandom_range(6, 0);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    grad_x_i = item.gx;
    grad_y_i = item.gy;
    do @(posedge clk_i); while (in_stall_o);
    has_res = predict_pixel(item.gx, item.gy, res);
    if (item.typed) pending_results = {pending_results, item.want};
    else if (has_res) pending_results = {pending_results, res};
    @(negedge clk_i);
  endtask

  function automatic grad_row_t rand_grad();
    grad_row_t g;
    int unsigned pick;
    g.typed = 1'b0;
    g.want = '{default: '0};
    pick = $urandom_range(99);
    if (pick < 45) begin
      g.gx = 12'($urandom);
      g.gy = 12'($urandom);
    end else if (pick < 85) begin
      g.gx = 12'($signed($urandom_range(15)) - 8);
      g.gy = 12'($signed($urandom_range(15)) - 8);
    end else begin
      g.gx = ($urandom_range(1)) ? 12'sh800 : 12'sh7ff;
      g.gy = ($urandom_range(2) == 0) ? 12'sh000 : 12'($urandom);
    end
    return g;
  endfunction

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_grad(rand_grad());
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // receiver: random stall pattern, long hold on request
  always @(negedge clk_i) begin
    if (hold_busy) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_busy = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_busy = 1'b0;
        hold_req = 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    nms_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result x=%0d y=%0d mag=%0d", $realtime,
                 center_x_o, center_y_o, nms_magnitude_o);
      end else begin
        want = pending_results.pop_front();
        if (center_x_o !== want.cx) begin
          fail_count++;
          $display("%0t center_x expected %0d got %0d", $realtime, want.cx, center_x_o);
        end
        if (center_y_o !== want.cy) begin
          fail_count++;
          $display("%0t center_y expected %0d got %0d", $realtime, want.cy, center_y_o);
        end
        if (nms_magnitude_o !== want.mag) begin
          fail_count++;
          $display("%0t nms_magnitude at (%0d,%0d) expected %0d got %0d", $realtime,
                   want.cx, want.cy, want.mag, nms_magnitude_o);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  // 5x3 frame: gradient extremes in the first row, a flat middle row,
  // so every interior centre is zero and the results are known
  grad_row_t directed[15] = '{
    '{12'sh800, 12'sh800, 1'b0, '{default: '0}},
    '{12'sh7ff, 12'sh800, 1'b0, '{default: '0}},
    '{12'sh800, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh7ff, 1'b0, '{default: '0}},
    '{12'sh7ff, 12'sh7ff, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh001, 12'sh000, 1'b0, '{default: '0}},
    '{12'sh000, 12'shfff, 1'b0, '{default: '0}},
    '{12'shfff, 12'shfff, 1'b1, '{10'd1, 10'd1, 12'd0}},
    '{12'sh555, 12'shaaa, 1'b1, '{10'd2, 10'd1, 12'd0}},
    '{12'shaaa, 12'sh555, 1'b1, '{10'd3, 10'd1, 12'd0}}
  };

  initial begin
    int unsigned rand_items;
    int unsigned w, h, frames;
    logic [gnms_pkg::MagW-1:0] thr;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    configure(12'd5, 12'd3, 12'd0);
    foreach (directed[i]) send_grad(directed[i]);
    drain();

    // sizes below the floor clamp to 3, threshold above any magnitude
    stall_pct = 30;
    configure(12'd0, 12'd0, 12'hfff);
    send_random(18);
    drain();

    // oversize clamps to the maximum; stop early in row zero
    stall_pct = 10;
    no_gaps = 1'b1;
    configure(12'd2047, 12'hfff, 12'd2896);
    send_random(20);
    drain();

    // shrink the frame below the current column, then finish it
    no_gaps = 1'b0;
    configure(12'd8, 12'd5, 12'd3);
    send_random(32);
    drain();

    rand_items = 0;
    for (int ph = 0; rand_items < 800; ph++) begin
      w = $urandom_range(12, 3);
      h = $urandom_range(8, 3);
      frames = $urandom_range(2, 1);
      case ($urandom_range(3))
        0: thr = '0;
        1: thr = 12'($urandom_range(12));
        2: thr = 12'($urandom_range(2896));
        default: thr = 12'($urandom_range(40));
      endcase
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 60;
      endcase
      no_gaps = ($urandom_range(3) == 0);
      // large frame under a long receiver hold so the block backs up
      if (ph == 1) begin
        w = 12;
        h = 8;
        frames = 2;
        no_gaps = 1'b1;
        hold_req = 1'b1;
      end
      configure(12'(w), 12'(h), thr);
      send_random(w * h * frames);
      rand_items += w * h * frames;
      drain();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
